// ----- hw/rtl/sitda_pkg.sv -----
// Shared constants and helpers for the signed integer to decimal text converter.
`default_nettype none
package sitda_pkg;

	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int QUEUE_DEPTH        = 2;
	localparam int BITS_PER_STEP      = 4;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;
	localparam logic [7:0] ASCII_NINE  = 8'd57;

	// add-3 correction of the shift-and-add-3 binary to BCD scheme
	localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [3:0] DIGIT_ADJ     = 4'd3;

	// decimal digits needed for the largest magnitude, 2^(bits-1)
	function automatic int dec_digits(input int bits);
		logic [63:0] x;
		int n;
		x = 64'd1 << (bits - 1);
		n = 0;
		while (x != 64'd0) begin
			n++;
			x = x / 64'd10;
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// Top level: signed integer in, decimal ASCII characters out, one per transfer.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------
//   input    | push / full      | value [VALUE_BITS-1:0]
//   result   | empty / pop      | char_code [7:0], last_char
//
// The back stage takes a number from the queue, runs the BCD conversion loop
// (four bits per cycle), finds the leading digit, then emits the characters
// one at a time (up to 11 at 32 bits), each when the result register is empty or popped.
// A two-entry queue behind the front register lets numbers come in while the
// back stage converts. arst_n clears all control state; the result register
// holds its character until it is popped, and the back stage waits on it.
`default_nettype none
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sitda_pkg::DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  push,
	output logic                       full,
	output logic [7:0]                 char_code,
	output logic                       last_char,
	output logic                       empty,
	input  wire logic                  pop
);
	import sitda_pkg::*;

	logic                  q_wr;
	logic                  q_rd;
	logic                  q_full;
	logic                  q_empty;
	logic                  neg_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	logic [VALUE_BITS:0]   q_rd_data;

	sitda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.push   (push),
		.full   (full),
		.q_full (q_full),
		.q_wr   (q_wr),
		.neg_s1 (neg_s1),
		.mag_s1 (mag_s1)
	);

	sitda_queue #(.WIDTH(VALUE_BITS + 1)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data ({neg_s1, mag_s1}),
		.q_full  (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.q_empty (q_empty)
	);

	sitda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_neg     (q_rd_data[VALUE_BITS]),
		.q_mag     (q_rd_data[VALUE_BITS-1:0]),
		.q_rd      (q_rd),
		.char_code (char_code),
		.last_char (last_char),
		.empty     (empty),
		.pop       (pop)
	);

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (char_code == ASCII_MINUS) ||
			(char_code >= ASCII_ZERO && char_code <= ASCII_NINE))
		else $error("result character out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && char_code == ASCII_MINUS) |-> !last_char)
		else $error("minus sign flagged as last character");

	a_queue_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr)
		else $error("write into full queue");

	a_queue_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_rd)
		else $error("read from empty queue");

endmodule
`default_nettype wire

// ----- hw/rtl/sitda_front.sv -----
// Front stage: takes numbers in, splits them into sign and unsigned magnitude.
`default_nettype none
module sitda_front #(
	parameter int VALUE_BITS = sitda_pkg::DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  q_full,
	output logic                       q_wr,
	output logic                       neg_s1,
	output logic [VALUE_BITS-1:0]      mag_s1
);
	import sitda_pkg::*;

	logic valid_s1;
	logic accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	// magnitude taken as unsigned, so the most negative value keeps its sign bit
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= value[VALUE_BITS-1];
			mag_s1 <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sitda_queue.sv -----
// Short queue between the front and back stages.
`default_nettype none
module sitda_queue #(
	parameter int WIDTH = sitda_pkg::DEFAULT_VALUE_BITS + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  q_full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  q_empty
);
	import sitda_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign q_full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PW'(1);
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sitda_back.sv -----
// Back stage: binary to BCD conversion and character output register.
`default_nettype none
module sitda_back #(
	parameter int VALUE_BITS = sitda_pkg::DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire logic                  q_neg,
	input  wire logic [VALUE_BITS-1:0] q_mag,
	output logic                       q_rd,
	output logic [7:0]                 char_code,
	output logic                       last_char,
	output logic                       empty,
	input  wire logic                  pop
);
	import sitda_pkg::*;

	localparam int NDIG  = dec_digits(VALUE_BITS);
	localparam int BW    = NDIG * 4;
	localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PADW  = STEPS * BITS_PER_STEP;
	localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int DW    = (NDIG > 1) ? $clog2(NDIG) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEAD,
		ST_EMIT
	} state_t;

	state_t         state_q;
	logic [BW-1:0]  bcd_q;
	logic [PADW-1:0] sh_q;
	logic [CW-1:0]  cnt_q;
	logic [DW-1:0]  pos_q;
	logic           sign_pend_q;
	logic           out_valid_q;
	logic [7:0]     char_q;
	logic           last_q;

	logic [BW-1:0]   bcd_n;
	logic [PADW-1:0] sh_n;
	logic [DW-1:0]   lead_pos;
	logic [3:0]      digit;
	logic            emit_ok;

	assign empty     = !out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;
	assign emit_ok   = !out_valid_q || pop;
	assign q_rd      = (state_q == ST_IDLE) && !q_empty;
	assign digit     = bcd_q[pos_q*4 +: 4];

	// several bits of shift-and-add-3 per cycle
	always_comb begin
		bcd_n = bcd_q;
		sh_n  = sh_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[d*4 +: 4] >= DIGIT_ADJ_MIN) begin
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + DIGIT_ADJ;
				end
			end
			bcd_n = {bcd_n[BW-2:0], sh_n[PADW-1]};
			sh_n  = {sh_n[PADW-2:0], 1'b0};
		end
	end

	// highest nonzero digit; zero falls to the ones digit
	always_comb begin
		lead_pos = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) lead_pos = DW'(d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sign_pend_q <= 1'b0;
			cnt_q       <= '0;
			pos_q       <= '0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						sign_pend_q <= q_neg;
						cnt_q       <= CW'(STEPS - 1);
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) state_q <= ST_LEAD;
				end
				ST_LEAD: begin
					pos_q   <= lead_pos;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
							char_q      <= ASCII_MINUS;
							last_q      <= 1'b0;
						end else begin
							char_q <= ASCII_ZERO + {4'd0, digit};
							last_q <= (pos_q == '0);
							if (pos_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								pos_q <= pos_q - DW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !q_empty) begin
			bcd_q <= '0;
			sh_q  <= PADW'(q_mag);
		end else if (state_q == ST_CONV) begin
			bcd_q <= bcd_n;
			sh_q  <= sh_n;
		end
	end

endmodule
`default_nettype wire

// ----- tb/sv/signed_int_to_decimal_ascii_tb.sv -----
// Testbench for signed_int_to_decimal_ascii: random and corner integers, checked per character.
`timescale 1ns / 100ps
module signed_int_to_decimal_ascii_tb;
	import sitda_pkg::*;

	localparam int          VBITS       = 32;
	localparam int          NUM_RANDOM  = 450;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          TAIL_CYCLES = 60;
	localparam logic [31:0] RADIX       = 32'd10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} ascii_char_t;

	// expected text of each accepted number, one entry per character
	class text_scoreboard;
		ascii_char_t pending_chars[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function void note_value(logic [VBITS-1:0] v);
			logic [VBITS-1:0] mag;
			logic [3:0]       digit_buf[20];
			int               nd;
			ascii_char_t      c;
			nd = 0;
			if (v[VBITS-1]) begin
				c.code = ASCII_MINUS;
				c.last = 1'b0;
				pending_chars.push_back(c);
			end
			// unsigned negate, so the most negative value keeps all its digits
			mag = v[VBITS-1] ? ({VBITS{1'b0}} - v) : v;
			do begin
				digit_buf[nd] = 4'(mag % RADIX);
				mag = mag / RADIX;
				nd++;
			end while (mag != 0);
			for (int i = nd - 1; i >= 0; i--) begin
				c.code = ASCII_ZERO + 8'(digit_buf[i]);
				c.last = (i == 0);
				pending_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [7:0] code, logic last);
			ascii_char_t exp_c;
			if (pending_chars.size() == 0) begin
				$error("char_code: unexpected transfer, actual %0d last_char %0b", code, last);
				errors++;
				return;
			end
			exp_c = pending_chars.pop_front();
			if (code !== exp_c.code) begin
				$error("char_code: expected %0d actual %0d", exp_c.code, code);
				errors++;
			end
			if (last !== exp_c.last) begin
				$error("last_char: expected %0b actual %0b", exp_c.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic [VBITS-1:0] value;
	logic             push;
	logic             full;
	logic [7:0]       char_code;
	logic             last_char;
	logic             empty;
	logic             pop;

	text_scoreboard   sb;
	int unsigned      cycle_count;
	logic             drain_mode;
	logic [1:0]       stall_mode;
	logic [7:0]       stall_pattern;

	signed_int_to_decimal_ascii #(.VALUE_BITS(VBITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.last_char (last_char),
		.empty     (empty),
		.pop       (pop)
	);

	// starts low so there is no rising edge at time zero
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("signed_int_to_decimal_ascii_tb NOT OK");
			$finish;
		end
	end

	// receiver: checks each popped character under a random stall mode, always popping once draining
	always @(posedge clk) begin
		if (pop && !empty)
			sb.check_char(char_code, last_char);
		if (cycle_count % 64 == 0) begin
			stall_mode    <= 2'($urandom_range(3, 0));
			stall_pattern <= 8'($urandom);
		end else begin
			stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
		end
		if (drain_mode) begin
			pop <= 1'b1;
		end else begin
			case (stall_mode)
				2'd0: pop <= 1'b1;
				2'd1: pop <= 1'($urandom);
				2'd2: pop <= ($urandom_range(3, 0) == 0);
				default: pop <= stall_pattern[0];
			endcase
		end
	end

	// holds push high across back-to-back transfers; caller lowers it
	task automatic send_value(logic [VBITS-1:0] v);
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		sb.note_value(v);
	endtask

	task automatic idle_gap();
		int gap;
		gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(25, 1);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [VBITS-1:0] random_value();
		logic [VBITS-1:0] lim;
		logic [VBITS-1:0] mag;
		int               nd;
		if ($urandom_range(4, 0) == 0)
			return VBITS'($urandom);
		// pick a digit-count bound first so short numbers come up often, not just long ones
		nd  = $urandom_range(10, 1);
		lim = 1;
		for (int i = 0; i < nd; i++)
			lim = lim * RADIX;
		mag = (nd == 10) ? VBITS'($urandom) : VBITS'($urandom_range(lim - 1, 0));
		return $urandom_range(1, 0) ? ({VBITS{1'b0}} - mag) : mag;
	endfunction

	logic [VBITS-1:0] corner_values[] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99,
		32'd100, -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
		32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd1999999999,
		-32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd5, 32'd42
	};

	initial begin
		int burst;
		int sent;
		sb          = new();
		cycle_count = 0;
		drain_mode  = 1'b0;
		stall_mode  = 2'd0;
		stall_pattern = 8'hA5;
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		value       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, back to back
		foreach (corner_values[i])
			send_value(corner_values[i]);
		push <= 1'b0;
		@(posedge clk);

		sent = 0;
		while (sent < NUM_RANDOM) begin
			burst = $urandom_range(12, 1);
			for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
				send_value(random_value());
				sent++;
			end
			idle_gap();
		end
		push <= 1'b0;

		drain_mode <= 1'b1;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("signed_int_to_decimal_ascii_tb OK");
		else
			$display("signed_int_to_decimal_ascii_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_front.sv
hw/rtl/sitda_queue.sv
hw/rtl/sitda_back.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
